// ===== sv/auvc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the angle / unit vector converter.
// No dependencies; auvc_cordic and the converter top level import this package.
package auvc_pkg;

    localparam int STAGES = 24;   // CORDIC iterations, 12..32
    localparam int FRAC   = 16;   // fraction bits of all fixed-point values, 8..24
    localparam int CW     = 60;   // CORDIC component width (vector input scaled by 2^24)

    typedef enum logic {
        CMD_ANGLE_TO_VEC = 1'b0,
        CMD_VEC_TO_ANGLE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        REG_RADIANS   = 2'd0,
        REG_SYMMETRIC = 2'd1,
        REG_MISSING   = 2'd2,
        REG_ZERO_TOL  = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        t_cmd       cmd;
        logic       miss;
        logic       near_zero;
        logic [1:0] quad;
    } t_side;

    localparam logic signed [CW-1:0] INV_GAIN_Q30 = CW'(652032874);
    localparam logic [63:0] INV_PI_Q64 = 64'h517CC1B727220A95;
    localparam logic [63:0] TWO_PI_Q29 = 64'd3373259426;

    // Angle to phase reciprocals (phase = angle * recip / 2^32)
    localparam logic [63:0] DEG_RECIP = ((64'd1 << (64 - FRAC)) + 64'd180) / 64'd360;
    localparam logic [63:0] RAD_RECIP = (INV_PI_Q64 + (64'd1 << FRAC)) >> (FRAC + 1);

    // Phase to angle
    localparam int SH_DEG = 32 - FRAC;
    localparam int SH_RAD = 61 - FRAC;
    localparam logic [63:0] TURN_DEG = 64'd360 << FRAC;
    localparam logic [63:0] HALF_DEG = 64'd180 << FRAC;
    localparam logic [63:0] TURN_RAD =
        (TWO_PI_Q29 + (64'd1 << (28 - FRAC))) >> (29 - FRAC);
    localparam logic [63:0] HALF_RAD =
        (TWO_PI_Q29 + (64'd1 << (29 - FRAC))) >> (30 - FRAC);

    localparam int COMP_SH = 30 - FRAC;

    localparam logic [31:0] ATAN_TURN [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
    };

endpackage
`default_nettype wire

// ===== sv/auvc_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Input channel: one command beat with angle and vector operands.
// Depends on nothing.
interface auvc_in_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic signed [31:0] in_angle;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;

    modport source (output valid, command, in_angle, in_x, in_y, input ready);
    modport sink   (input valid, command, in_angle, in_x, in_y, output ready);
endinterface
`default_nettype wire

// ===== sv/auvc_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Output channel: one result beat per command.
// Depends on nothing.
interface auvc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_angle;
    logic               was_missing;

    modport source (output valid, out_x, out_y, out_angle, was_missing, input ready);
    modport sink   (input valid, out_x, out_y, out_angle, was_missing, output ready);
endinterface
`default_nettype wire

// ===== sv/auvc_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pipelined CORDIC, one iteration per register stage, rotation or vectoring per beat.
// Depends on auvc_pkg.
module auvc_cordic (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_vld,
    input  wire logic signed [auvc_pkg::CW-1:0] i_x,
    input  wire logic signed [auvc_pkg::CW-1:0] i_y,
    input  wire logic [31:0]                  i_z,
    input  wire auvc_pkg::t_side              i_side,
    output logic                              o_vld,
    output logic signed [auvc_pkg::CW-1:0]    o_x,
    output logic signed [auvc_pkg::CW-1:0]    o_y,
    output logic [31:0]                       o_z,
    output auvc_pkg::t_side                   o_side
);
    import auvc_pkg::*;

    logic                 r_vld  [STAGES];
    logic signed [CW-1:0] r_x    [STAGES];
    logic signed [CW-1:0] r_y    [STAGES];
    logic [31:0]          r_z    [STAGES];
    t_side                r_side [STAGES];

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic                 w_vld;
        logic signed [CW-1:0] w_x;
        logic signed [CW-1:0] w_y;
        logic [31:0]          w_z;
        t_side                w_side;
        logic                 w_dir;
        logic signed [CW-1:0] n_x;
        logic signed [CW-1:0] n_y;
        logic [31:0]          n_z;

        if (i == 0) begin : g_first
            assign w_vld  = i_vld;
            assign w_x    = i_x;
            assign w_y    = i_y;
            assign w_z    = i_z;
            assign w_side = i_side;
        end else begin : g_next
            assign w_vld  = r_vld[i-1];
            assign w_x    = r_x[i-1];
            assign w_y    = r_y[i-1];
            assign w_z    = r_z[i-1];
            assign w_side = r_side[i-1];
        end

        // rotation drives z toward zero, vectoring drives y toward zero
        assign w_dir = (w_side.cmd == CMD_VEC_TO_ANGLE) ? w_y[CW-1] : ~w_z[31];

        always_comb begin
            if (w_dir) begin
                n_x = w_x - (w_y >>> i);
                n_y = w_y + (w_x >>> i);
                n_z = w_z - ATAN_TURN[i];
            end else begin
                n_x = w_x + (w_y >>> i);
                n_y = w_y - (w_x >>> i);
                n_z = w_z + ATAN_TURN[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_en) begin
                r_vld[i] <= w_vld;
            end
            if (i_en) begin
                r_x[i]    <= n_x;
                r_y[i]    <= n_y;
                r_z[i]    <= n_z;
                r_side[i] <= w_side;
            end
        end
    end

    assign o_vld  = r_vld[STAGES-1];
    assign o_x    = r_x[STAGES-1];
    assign o_y    = r_y[STAGES-1];
    assign o_z    = r_z[STAGES-1];
    assign o_side = r_side[STAGES-1];

endmodule
`default_nettype wire

// ===== sv/angle_unit_vector_converter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Angle / unit vector converter: cos/sin of an angle, or atan2 of a vector.
// Depends on auvc_pkg, auvc_in_if, auvc_out_if, auvc_cordic.
//
// Usage:
//   i_in carries one command beat (command, in_angle, in_x, in_y); o_out returns
//   exactly one result beat per command, in order. Command 0 yields out_x/out_y
//   (cos, sin), command 1 yields out_angle. All values are Q15.16 signed.
//   Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data while idle.
// Timing:
//   The pipeline has one operand stage, one setup stage, one stage per
//   CORDIC iteration (24), and three output stages (quadrant fold, phase
//   multiply, round and wrap). A beat is accepted every cycle unless the output stalls.
// Reset:
//   Synchronous, active low; clears all valid bits and restores the register
//   defaults (degrees, range [0, turn), missing pattern 0x80000000, tolerance 0).
// Stall:
//   When o_out.ready is low with a result waiting, the whole pipeline holds,
//   bubbles included, and i_in.ready drops until that beat is taken.
module angle_unit_vector_converter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    auvc_in_if.sink          i_in,
    auvc_out_if.source       o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);
    import auvc_pkg::*;

    // configuration registers
    logic        r_rad;
    logic        r_sym;
    logic [31:0] r_miss_pat;
    logic [15:0] r_zero_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rad      <= 1'b0;
            r_sym      <= 1'b0;
            r_miss_pat <= 32'h8000_0000;
            r_zero_tol <= 16'd0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_RADIANS:   r_rad      <= i_cfg_data[0];
                REG_SYMMETRIC: r_sym      <= i_cfg_data[0];
                REG_MISSING:   r_miss_pat <= i_cfg_data;
                REG_ZERO_TOL:  r_zero_tol <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic w_en;
    logic r5_vld;
    assign w_en        = ~r5_vld | o_out.ready;
    assign i_in.ready  = w_en;

    // ---- stage 1: operand checks and angle-to-phase partial products ----
    logic               w_miss;
    logic [31:0]        w_ax;
    logic [31:0]        w_ay;
    logic               w_nz;
    logic [63:0]        w_recip;
    logic signed [64:0] w_plo;
    logic [31:0]        w_phi;

    assign w_miss = (i_in.command == CMD_VEC_TO_ANGLE)
                  ? ((i_in.in_x == r_miss_pat) || (i_in.in_y == r_miss_pat))
                  : (i_in.in_angle == r_miss_pat);
    assign w_ax    = i_in.in_x[31] ? 32'(-i_in.in_x) : i_in.in_x;
    assign w_ay    = i_in.in_y[31] ? 32'(-i_in.in_y) : i_in.in_y;
    assign w_nz    = (w_ax <= {16'd0, r_zero_tol}) && (w_ay <= {16'd0, r_zero_tol});
    assign w_recip = r_rad ? RAD_RECIP : DEG_RECIP;
    assign w_plo   = i_in.in_angle * $signed({1'b0, w_recip[31:0]});
    assign w_phi   = i_in.in_angle * w_recip[63:32];

    logic               r1_vld;
    t_side              r1_side;
    logic [63:0]        r1_plo;
    logic [31:0]        r1_phi;
    logic signed [31:0] r1_x;
    logic signed [31:0] r1_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_in.valid;
        end
        if (w_en) begin
            r1_side.cmd       <= t_cmd'(i_in.command);
            r1_side.miss      <= w_miss;
            r1_side.near_zero <= w_nz;
            r1_side.quad      <= 2'd0;
            r1_plo            <= w_plo[63:0];
            r1_phi            <= w_phi;
            r1_x              <= i_in.in_x;
            r1_y              <= i_in.in_y;
        end
    end

    // ---- stage 2: CORDIC start values ----
    logic [31:0]          w_ph;
    logic [31:0]          w_ph_r;
    logic [1:0]           w_quad;
    logic signed [CW-1:0] w_xe;
    logic signed [CW-1:0] w_ye;
    logic signed [CW-1:0] n2_x;
    logic signed [CW-1:0] n2_y;
    logic [31:0]          n2_z;
    t_side                n2_side;

    assign w_ph   = r1_plo[63:32] + r1_phi + {31'd0, r1_plo[31]};
    assign w_ph_r = w_ph + 32'h2000_0000;
    assign w_quad = w_ph_r[31:30];
    assign w_xe   = CW'(r1_x) <<< 24;
    assign w_ye   = CW'(r1_y) <<< 24;

    always_comb begin
        n2_side = r1_side;
        if (r1_side.cmd == CMD_VEC_TO_ANGLE) begin
            // fold the left half plane over and start at half a turn
            n2_x = r1_x[31] ? -w_xe : w_xe;
            n2_y = r1_x[31] ? -w_ye : w_ye;
            n2_z = r1_x[31] ? 32'h8000_0000 : 32'd0;
        end else begin
            n2_x         = INV_GAIN_Q30;
            n2_y         = '0;
            n2_z         = w_ph - {w_quad, 30'd0};
            n2_side.quad = w_quad;
        end
    end

    logic                 r2_vld;
    logic signed [CW-1:0] r2_x;
    logic signed [CW-1:0] r2_y;
    logic [31:0]          r2_z;
    t_side                r2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r2_vld <= r1_vld;
        end
        if (w_en) begin
            r2_x    <= n2_x;
            r2_y    <= n2_y;
            r2_z    <= n2_z;
            r2_side <= n2_side;
        end
    end

    // ---- CORDIC iterations ----
    logic                 c_vld;
    logic signed [CW-1:0] c_x;
    logic signed [CW-1:0] c_y;
    logic [31:0]          c_z;
    t_side                c_side;

    auvc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r2_vld),
        .i_x     (r2_x),
        .i_y     (r2_y),
        .i_z     (r2_z),
        .i_side  (r2_side),
        .o_vld   (c_vld),
        .o_x     (c_x),
        .o_y     (c_y),
        .o_z     (c_z),
        .o_side  (c_side)
    );

    // ---- stage 3: quadrant unfold, phase magnitude ----
    logic signed [CW-1:0] n3_x;
    logic signed [CW-1:0] n3_y;
    logic [31:0]          w_phase;
    logic [31:0]          n3_mag;
    logic                 n3_neg;

    always_comb begin
        unique case (c_side.quad)
            2'd0:    begin n3_x =  c_x; n3_y =  c_y; end
            2'd1:    begin n3_x = -c_y; n3_y =  c_x; end
            2'd2:    begin n3_x = -c_x; n3_y = -c_y; end
            default: begin n3_x =  c_y; n3_y = -c_x; end
        endcase
    end

    assign w_phase = c_side.near_zero ? 32'd0 : c_z;
    assign n3_neg  = r_sym & w_phase[31];
    assign n3_mag  = n3_neg ? 32'(-w_phase) : w_phase;

    logic                 r3_vld;
    logic signed [CW-1:0] r3_x;
    logic signed [CW-1:0] r3_y;
    logic [31:0]          r3_mag;
    logic                 r3_neg;
    t_side                r3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_en) begin
            r3_vld <= c_vld;
        end
        if (w_en) begin
            r3_x    <= n3_x;
            r3_y    <= n3_y;
            r3_mag  <= n3_mag;
            r3_neg  <= n3_neg;
            r3_side <= c_side;
        end
    end

    // ---- stage 4: phase times turn, component rounding ----
    logic signed [CW-1:0] w_rx;
    logic signed [CW-1:0] w_ry;
    logic [63:0]          n4_prod;

    assign w_rx    = (r3_x + (CW'(1) <<< (COMP_SH - 1))) >>> COMP_SH;
    assign w_ry    = (r3_y + (CW'(1) <<< (COMP_SH - 1))) >>> COMP_SH;
    assign n4_prod = r3_mag * (r_rad ? TWO_PI_Q29[31:0] : 32'd360);

    logic        r4_vld;
    logic [63:0] r4_prod;
    logic [31:0] r4_cx;
    logic [31:0] r4_cy;
    logic        r4_neg;
    t_side       r4_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (w_en) begin
            r4_vld <= r3_vld;
        end
        if (w_en) begin
            r4_prod <= n4_prod;
            r4_cx   <= w_rx[31:0];
            r4_cy   <= w_ry[31:0];
            r4_neg  <= r3_neg;
            r4_side <= r3_side;
        end
    end

    // ---- stage 5: round and wrap the angle, output register ----
    logic [64:0]        w_rnd;
    logic [64:0]        w_v;
    logic [63:0]        w_turn;
    logic [63:0]        w_half;
    logic signed [65:0] w_r;
    logic signed [65:0] w_ang;

    assign w_rnd  = r_rad ? ({1'b0, r4_prod} + (65'd1 << (SH_RAD - 1)))
                          : ({1'b0, r4_prod} + (65'd1 << (SH_DEG - 1)));
    assign w_v    = r_rad ? (w_rnd >> SH_RAD) : (w_rnd >> SH_DEG);
    assign w_turn = r_rad ? TURN_RAD : TURN_DEG;
    assign w_half = r_rad ? HALF_RAD : HALF_DEG;
    assign w_r    = r4_neg ? -$signed({1'b0, w_v}) : $signed({1'b0, w_v});

    always_comb begin
        w_ang = w_r;
        if (r_sym) begin
            if (w_r >= $signed({2'b00, w_half})) begin
                w_ang = w_r - $signed({2'b00, w_turn});
            end
        end else if (w_r >= $signed({2'b00, w_turn})) begin
            w_ang = w_r - $signed({2'b00, w_turn});
        end
    end

    logic        r5_miss;
    logic [31:0] r5_x;
    logic [31:0] r5_y;
    logic [31:0] r5_ang;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (w_en) begin
            r5_vld <= r4_vld;
        end
        if (w_en) begin
            r5_miss <= r4_side.miss;
            if (r4_side.miss) begin
                r5_x   <= r_miss_pat;
                r5_y   <= r_miss_pat;
                r5_ang <= r_miss_pat;
            end else if (r4_side.cmd == CMD_VEC_TO_ANGLE) begin
                r5_x   <= 32'd0;
                r5_y   <= 32'd0;
                r5_ang <= w_ang[31:0];
            end else begin
                r5_x   <= r4_cx;
                r5_y   <= r4_cy;
                r5_ang <= 32'd0;
            end
        end
    end

    assign o_out.valid       = r5_vld;
    assign o_out.out_x       = r5_x;
    assign o_out.out_y       = r5_y;
    assign o_out.out_angle   = r5_ang;
    assign o_out.was_missing = r5_miss;

endmodule
`default_nettype wire

// ===== sv/auvc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks for the converter, bound to the top level.
// Depends on angle_unit_vector_converter.
module auvc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] i_out_x,
    input wire logic [31:0] i_out_y,
    input wire logic [31:0] i_out_angle,
    input wire logic        i_out_missing
);
    // a stalled result beat stays up
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat right after reset");

    // a free output side never blocks the input
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("input stalled with output free");

    // a missing beat carries the same pattern on every value field
    a_missing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_missing |-> (i_out_x == i_out_y) && (i_out_y == i_out_angle))
        else $error("missing beat with mixed value fields");
endmodule

bind angle_unit_vector_converter auvc_checker u_auvc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_x       (o_out.out_x),
    .i_out_y       (o_out.out_y),
    .i_out_angle   (o_out.out_angle),
    .i_out_missing (o_out.was_missing)
);
`default_nettype wire
